// ===== rtl/lppp_pkg.sv =====
// ----------------------------------------------------------------------------
// lppp_pkg
// Shared types and constants for the lidar point to pixel projection block.
// ----------------------------------------------------------------------------
package lppp_pkg;

    localparam int COORD_W = 24;   // lidar coordinate, signed
    localparam int CAM_W   = 25;   // camera coordinate, signed
    localparam int FOCAL_W = 27;
    localparam int DEPTH_W = 23;
    localparam int SIZE_W  = 11;
    localparam int PIX_W   = 10;
    localparam int CFG_W   = 27;
    localparam int IDX_W   = 3;
    localparam int NUM_W   = 54;   // c*Z + X*f, signed
    localparam int REM_W   = 56;   // 2|num| + den, unsigned

    localparam logic [IDX_W-1:0] CFG_FOCAL  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CU     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_CV     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DMIN   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_DMAX   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_WIDTH  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 3'd6;

    typedef struct packed {
        logic [FOCAL_W-1:0] focal_length;
        logic [FOCAL_W-1:0] center_u;
        logic [FOCAL_W-1:0] center_v;
        logic [DEPTH_W-1:0] depth_min;
        logic [DEPTH_W-1:0] depth_max;
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
    } t_cfg;

    // sideband that rides along the divider chain
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;    // saturated Z, also the divisor base
        logic               win_ok;   // 0 < Z, depth_min <= Z <= depth_max
        logic               neg_u;    // numerator sign, column
        logic               neg_v;    // numerator sign, row
    } t_side;

endpackage

// ===== rtl/lidar_point_pixel_projection_top.sv =====
// Throughput is one point per clock while the output is not stalled; the pipeline is 5 front
// stages, then $clog2(MAX_DIM)+1 divider cells (one quotient bit each), then one output
// register. Every stage has its own valid bit, so the pipeline keeps filling while a
// finished result waits at the output.
// ----------------------------------------------------------------------------
// lidar_point_pixel_projection_top
// Projects lidar points onto the image plane of a pinhole camera.
// ----------------------------------------------------------------------------
// Flow:
//   - front: camera frame X=-y, Y=-z-0.064, Z=x-0.0369, depth window, the
//     products c*Z and X*f, then the dividend 2|c*Z+X*f| + Z*2^F per axis.
//   - cells: a chain of restoring-division cells, quotient bit K per cell,
//     from K = $clog2(MAX_DIM) (overflow bit) down to 0. The divisor is
//     Z*2^(F+1), so the quotient is the pixel rounded half away from zero.
//   - back: image bounds check, result register.
// A request on the config port may only be issued while the block is idle.
// ----------------------------------------------------------------------------
module lidar_point_pixel_projection_top #(
    parameter int MAX_DIM   = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // config write port
    input  logic                         i_cfg_we,
    input  logic [lppp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [lppp_pkg::CFG_W-1:0]   i_cfg_data,
    // point requests in
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [71:0]                  i_s_tdata,  // point_x, point_y, point_z
    // pixel results out
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [47:0]                  o_m_tdata,  // pixel_u, pixel_v, depth, pad
    output logic [0:0]                   o_m_tuser   // hit
);
    localparam int QB = $clog2(MAX_DIM);
    localparam int QW = QB + 1;
    localparam int NC = QB + 1;
    localparam int RW = lppp_pkg::REM_W;

    // ---------------- config registers ----------------
    lppp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_length <= 27'd39970304;
            r_cfg.center_u     <= 27'd20709510;
            r_cfg.center_v     <= 27'd16390011;
            r_cfg.depth_min    <= 23'd6554;
            r_cfg.depth_max    <= 23'd655360;
            r_cfg.image_width  <= 11'd640;
            r_cfg.image_height <= 11'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lppp_pkg::CFG_FOCAL:  r_cfg.focal_length <= i_cfg_data;
                lppp_pkg::CFG_CU:     r_cfg.center_u     <= i_cfg_data;
                lppp_pkg::CFG_CV:     r_cfg.center_v     <= i_cfg_data;
                lppp_pkg::CFG_DMIN:   r_cfg.depth_min    <= i_cfg_data[22:0];
                lppp_pkg::CFG_DMAX:   r_cfg.depth_max    <= i_cfg_data[22:0];
                lppp_pkg::CFG_WIDTH:  r_cfg.image_width  <= i_cfg_data[10:0];
                lppp_pkg::CFG_HEIGHT: r_cfg.image_height <= i_cfg_data[10:0];
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // ---------------- chain wiring ----------------
    logic                  c_valid [NC+1];
    logic                  c_ready [NC+1];
    logic [RW-1:0]         c_rem_u [NC+1];
    logic [RW-1:0]         c_rem_v [NC+1];
    logic [QW-1:0]         c_q_u   [NC+1];
    logic [QW-1:0]         c_q_v   [NC+1];
    lppp_pkg::t_side       c_side  [NC+1];

    lppp_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_x     (i_s_tdata[23:0]),
        .i_y     (i_s_tdata[47:24]),
        .i_z     (i_s_tdata[71:48]),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_rem_u (c_rem_u[0]),
        .o_rem_v (c_rem_v[0]),
        .o_side  (c_side[0])
    );

    assign c_q_u[0] = '0;
    assign c_q_v[0] = '0;

    for (genvar gi = 0; gi < NC; gi++) begin : g_cell
        lppp_cell #(
            .FRAC_BITS (FRAC_BITS),
            .K         (QB - gi),
            .QW        (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[gi]),
            .o_ready (c_ready[gi]),
            .i_rem_u (c_rem_u[gi]),
            .i_rem_v (c_rem_v[gi]),
            .i_q_u   (c_q_u[gi]),
            .i_q_v   (c_q_v[gi]),
            .i_side  (c_side[gi]),
            .o_valid (c_valid[gi+1]),
            .i_ready (c_ready[gi+1]),
            .o_rem_u (c_rem_u[gi+1]),
            .o_rem_v (c_rem_v[gi+1]),
            .o_q_u   (c_q_u[gi+1]),
            .o_q_v   (c_q_v[gi+1]),
            .o_side  (c_side[gi+1])
        );
    end

    // final remainders are not needed past the last cell
    logic [lppp_pkg::PIX_W-1:0]   w_u, w_v;
    logic [lppp_pkg::DEPTH_W-1:0] w_dep;
    logic                         w_hit;
    logic                         w_rem_nz;

    assign w_rem_nz = |{c_rem_u[NC], c_rem_v[NC]};

    lppp_back #(
        .MAX_DIM (MAX_DIM),
        .QW      (QW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (c_valid[NC]),
        .o_ready (c_ready[NC]),
        .i_q_u   (c_q_u[NC]),
        .i_q_v   (c_q_v[NC]),
        .i_side  (c_side[NC]),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_u     (w_u),
        .o_v     (w_v),
        .o_depth (w_dep),
        .o_hit   (w_hit)
    );

    assign o_m_tdata = {5'b00000, w_dep, w_v, w_u};
    assign o_m_tuser = w_hit;

    // ---------------- assertions ----------------
    // a hit always has positive depth
    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[42:20] != '0))
        else $error("hit with zero depth");

    // a miss carries zero pixel coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[19:0] == '0))
        else $error("miss with nonzero pixel");

    // input only stalls when the whole chain, output included, is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && c_valid[0] && (w_rem_nz || !w_rem_nz)))
        else $error("input stalled with an empty slot");

endmodule

// ===== rtl/lppp_front.sv =====
// ----------------------------------------------------------------------------
// lppp_front
// Extrinsic transform, depth window, products and divider operands.
// ----------------------------------------------------------------------------
module lppp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lppp_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lppp_pkg::COORD_W-1:0]  i_x,
    input  logic [lppp_pkg::COORD_W-1:0]  i_y,
    input  logic [lppp_pkg::COORD_W-1:0]  i_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lppp_pkg::REM_W-1:0]    o_rem_u,
    output logic [lppp_pkg::REM_W-1:0]    o_rem_v,
    output lppp_pkg::t_side               o_side
);
    localparam int CW = lppp_pkg::CAM_W;
    localparam int NW = lppp_pkg::NUM_W;
    localparam int RW = lppp_pkg::REM_W;
    localparam int DW = lppp_pkg::DEPTH_W;
    localparam longint OFS_Y_L = ((longint'(64) << FRAC_BITS) + 500) / 1000;
    localparam longint OFS_Z_L = ((longint'(369) << FRAC_BITS) + 5000) / 10000;
    localparam logic signed [CW-1:0] OFS_Y = CW'(OFS_Y_L);
    localparam logic signed [CW-1:0] OFS_Z = CW'(OFS_Z_L);
    localparam logic signed [CW-1:0] DEPTH_TOP = CW'((1 << DW) - 1);

    // stage valids
    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    assign rdy_e   = !r_ve || i_ready;
    assign rdy_d   = !r_vd || rdy_e;
    assign rdy_c   = !r_vc || rdy_d;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_ve;

    // stage A: input capture
    logic signed [lppp_pkg::COORD_W-1:0] r_ax, r_ay, r_az;
    // stage B: camera frame
    logic signed [CW-1:0] r_bx, r_by;
    logic [DW-1:0]        r_bdep;
    logic                 r_bwin;
    // stage C: products
    logic [49:0]          r_ccu, r_ccv;
    logic signed [52:0]   r_cxf, r_cyf;
    logic [DW-1:0]        r_cdep;
    logic                 r_cwin;
    // stage D: numerators
    logic signed [NW-1:0] r_dnu, r_dnv;
    logic [DW-1:0]        r_ddep;
    logic                 r_dwin;
    // stage E: dividend 2|num| + den
    logic [RW-1:0]        r_eu, r_ev;
    lppp_pkg::t_side      r_eside;

    logic signed [CW-1:0] n_bx, n_by, n_bz;
    logic [DW-1:0]        n_bdep;
    logic                 n_bwin;
    logic [RW-1:0]        den, sh_u, sh_v, op_u, op_v;

    always_comb begin
        n_bx = -CW'(r_ay);
        n_by = -CW'(r_az) - OFS_Y;
        n_bz = CW'(r_ax) - OFS_Z;
        if (n_bz < 0) begin
            n_bdep = '0;
        end else if (n_bz > DEPTH_TOP) begin
            n_bdep = '1;
        end else begin
            n_bdep = n_bz[DW-1:0];
        end
        n_bwin = (n_bz > 0)
              && (n_bz >= $signed({2'b00, i_cfg.depth_min}))
              && (n_bz <= $signed({2'b00, i_cfg.depth_max}));
    end

    always_comb begin
        den  = RW'(r_ddep) << FRAC_BITS;
        sh_u = RW'({r_dnu, 1'b0});
        sh_v = RW'({r_dnv, 1'b0});
        if (r_dnu[NW-1] && (RW > NW + 1)) begin
            sh_u[RW-1:NW+1] = '1;
        end
        if (r_dnv[NW-1] && (RW > NW + 1)) begin
            sh_v[RW-1:NW+1] = '1;
        end
        op_u = r_dnu[NW-1] ? ~sh_u : sh_u;
        op_v = r_dnv[NW-1] ? ~sh_v : sh_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
            if (rdy_d) r_vd <= r_vc;
            if (rdy_e) r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_ax <= i_x;
            r_ay <= i_y;
            r_az <= i_z;
        end
        if (rdy_b) begin
            r_bx   <= n_bx;
            r_by   <= n_by;
            r_bdep <= n_bdep;
            r_bwin <= n_bwin;
        end
        if (rdy_c) begin
            r_ccu  <= 50'(i_cfg.center_u) * 50'(r_bdep);
            r_ccv  <= 50'(i_cfg.center_v) * 50'(r_bdep);
            r_cxf  <= 53'(r_bx * $signed({1'b0, i_cfg.focal_length}));
            r_cyf  <= 53'(r_by * $signed({1'b0, i_cfg.focal_length}));
            r_cdep <= r_bdep;
            r_cwin <= r_bwin;
        end
        if (rdy_d) begin
            r_dnu  <= $signed({4'b0000, r_ccu}) + NW'(r_cxf);
            r_dnv  <= $signed({4'b0000, r_ccv}) + NW'(r_cyf);
            r_ddep <= r_cdep;
            r_dwin <= r_cwin;
        end
        if (rdy_e) begin
            r_eu           <= den + op_u + RW'(r_dnu[NW-1]);
            r_ev           <= den + op_v + RW'(r_dnv[NW-1]);
            r_eside.depth  <= r_ddep;
            r_eside.win_ok <= r_dwin;
            r_eside.neg_u  <= r_dnu[NW-1];
            r_eside.neg_v  <= r_dnv[NW-1];
        end
    end

    assign o_rem_u = r_eu;
    assign o_rem_v = r_ev;
    assign o_side  = r_eside;

endmodule

// ===== rtl/lppp_cell.sv =====
// ----------------------------------------------------------------------------
// lppp_cell
// One restoring-division cell: produces quotient bit K for both axes.
// ----------------------------------------------------------------------------
module lppp_cell #(
    parameter int FRAC_BITS = 16,
    parameter int K         = 0,
    parameter int QW        = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lppp_pkg::REM_W-1:0]  i_rem_u,
    input  logic [lppp_pkg::REM_W-1:0]  i_rem_v,
    input  logic [QW-1:0]               i_q_u,
    input  logic [QW-1:0]               i_q_v,
    input  lppp_pkg::t_side             i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lppp_pkg::REM_W-1:0]  o_rem_u,
    output logic [lppp_pkg::REM_W-1:0]  o_rem_v,
    output logic [QW-1:0]               o_q_u,
    output logic [QW-1:0]               o_q_v,
    output lppp_pkg::t_side             o_side
);
    localparam int RW  = lppp_pkg::REM_W;
    localparam int DSW = lppp_pkg::DEPTH_W + FRAC_BITS + 1 + K;
    localparam int CW  = (RW > DSW) ? RW : DSW;

    logic          r_v;
    logic [RW-1:0] r_rem_u, r_rem_v;
    logic [QW-1:0] r_q_u, r_q_v;
    lppp_pkg::t_side r_side;

    logic [CW-1:0] dsh;
    logic [CW:0]   diff_u, diff_v;
    logic          ge_u, ge_v;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        dsh    = CW'(i_side.depth) << (FRAC_BITS + 1 + K);
        diff_u = {1'b0, CW'(i_rem_u)} - {1'b0, dsh};
        diff_v = {1'b0, CW'(i_rem_v)} - {1'b0, dsh};
        ge_u   = !diff_u[CW];
        ge_v   = !diff_v[CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem_u <= ge_u ? diff_u[RW-1:0] : i_rem_u;
            r_rem_v <= ge_v ? diff_v[RW-1:0] : i_rem_v;
            r_q_u   <= {i_q_u[QW-2:0], ge_u};
            r_q_v   <= {i_q_v[QW-2:0], ge_v};
            r_side  <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rem_u = r_rem_u;
    assign o_rem_v = r_rem_v;
    assign o_q_u   = r_q_u;
    assign o_q_v   = r_q_v;
    assign o_side  = r_side;

endmodule

// ===== rtl/lppp_back.sv =====
// ----------------------------------------------------------------------------
// lppp_back
// Image bounds check and output register.
// ----------------------------------------------------------------------------
module lppp_back #(
    parameter int MAX_DIM = 1024,
    parameter int QW      = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lppp_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [QW-1:0]                i_q_u,
    input  logic [QW-1:0]                i_q_v,
    input  lppp_pkg::t_side              i_side,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [lppp_pkg::PIX_W-1:0]   o_u,
    output logic [lppp_pkg::PIX_W-1:0]   o_v,
    output logic [lppp_pkg::DEPTH_W-1:0] o_depth,
    output logic                         o_hit
);
    localparam int LW = (QW > lppp_pkg::SIZE_W) ? QW : lppp_pkg::SIZE_W;
    localparam logic [LW-1:0] DIM_MAX = LW'(MAX_DIM);

    logic [LW-1:0] lim_u, lim_v, qu, qv;
    logic          ok_u, ok_v, hit;

    logic r_v, r_hit;
    logic [lppp_pkg::PIX_W-1:0]   r_u, r_v_pix;
    logic [lppp_pkg::DEPTH_W-1:0] r_dep;

    assign o_ready = !r_v || i_ready;

    always_comb begin
        lim_u = (LW'(i_cfg.image_width) > DIM_MAX) ? DIM_MAX : LW'(i_cfg.image_width);
        lim_v = (LW'(i_cfg.image_height) > DIM_MAX) ? DIM_MAX : LW'(i_cfg.image_height);
        qu    = LW'(i_q_u);
        qv    = LW'(i_q_v);
        // negative numerator only lands in the image when it rounds to zero
        ok_u  = (qu < lim_u) && (!i_side.neg_u || (qu == '0));
        ok_v  = (qv < lim_v) && (!i_side.neg_v || (qv == '0));
        hit   = i_side.win_ok && ok_u && ok_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_hit   <= hit;
            r_u     <= hit ? lppp_pkg::PIX_W'(i_q_u) : '0;
            r_v_pix <= hit ? lppp_pkg::PIX_W'(i_q_v) : '0;
            r_dep   <= i_side.depth;
        end
    end

    assign o_valid = r_v;
    assign o_u     = r_u;
    assign o_v     = r_v_pix;
    assign o_depth = r_dep;
    assign o_hit   = r_hit;

endmodule

// ===== tb/sv/tb_lidar_point_pixel_projection_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_point_pixel_projection_top
// Streams lidar points into the projection block and checks every pixel
// result against a behavioral predictor, across several camera settings.
// ----------------------------------------------------------------------------
module tb_lidar_point_pixel_projection_top;

    localparam int LATENCY   = 17;
    localparam int CYCLE_MAX = 1500000;
    localparam int PW        = lppp_pkg::PIX_W;
    localparam int DW        = lppp_pkg::DEPTH_W;
    localparam int SW        = lppp_pkg::SIZE_W;
    localparam int XW        = lppp_pkg::IDX_W;
    localparam int VW        = lppp_pkg::CFG_W;
    localparam logic signed [63:0] OFS_Y = 64'sd4194;   // 0.064 m
    localparam logic signed [63:0] OFS_Z = 64'sd2418;   // 0.0369 m

    // one point request (x in the lowest bits) and one projected pixel
    typedef struct packed {
        logic [23:0] z;
        logic [23:0] y;
        logic [23:0] x;
    } t_point;

    typedef struct packed {
        logic [PW-1:0] u;
        logic [PW-1:0] v;
        logic [DW-1:0] depth;
        logic          hit;
    } t_pixel;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [XW-1:0] i_cfg_idx = '0;
    logic [VW-1:0] i_cfg_data = '0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [71:0]   i_s_tdata = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [47:0]   o_m_tdata;
    logic [0:0]    o_m_tuser;

    lidar_point_pixel_projection_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor's copy of the camera registers
    lppp_pkg::t_cfg cam;
    t_point point_q[$];      // points waiting to be offered
    t_pixel pixel_q[$];      // pixels predicted, oldest first
    int     errors = 0;
    int     n_points = 0;
    int     n_pixels = 0;
    int     n_hits = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     hold_cycles = 0;  // receiver hold-off request, counted down below
    bit     hold_now;
    longint cycles = 0;

    // round(num/den) half away from zero, den > 0
    function automatic longint div_round(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -mag : mag;
    endfunction

    // one image axis; in_img tells whether 0 <= pixel < min(size, 1024)
    function automatic void axis_pixel(input longint coord, input longint z,
                                       input longint center, input longint size,
                                       output bit in_img, output longint pix);
        longint lim;
        pix = div_round(center * z + coord * longint'(cam.focal_length), z * 65536);
        lim = (size > 1024) ? 1024 : size;
        in_img = (pix >= 0) && (pix < lim);
    endfunction

    function automatic t_pixel project_point(t_point p);
        t_pixel r;
        longint cx, cy, cz, pu, pv;
        bit     ok_u, ok_v;
        cx = -longint'($signed(p.y));
        cy = -longint'($signed(p.z)) - OFS_Y;
        cz = longint'($signed(p.x)) - OFS_Z;
        r = '0;
        if (cz < 0) r.depth = '0;
        else if (cz > 8388607) r.depth = '1;
        else r.depth = cz[DW-1:0];
        if (cz > 0 && cz >= longint'(cam.depth_min) && cz <= longint'(cam.depth_max)) begin
            axis_pixel(cx, cz, longint'(cam.center_u), longint'(cam.image_width), ok_u, pu);
            axis_pixel(cy, cz, longint'(cam.center_v), longint'(cam.image_height), ok_v, pv);
            if (ok_u && ok_v) begin
                r.hit = 1'b1;
                r.u = pu[PW-1:0];
                r.v = pv[PW-1:0];
            end
        end
        return r;
    endfunction

    // driver: offers queued points, predicts on each accepted request
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            pixel_q.push_back(project_point(t_point'(i_s_tdata)));
            n_points++;
            void'(point_q.pop_front());
        end
        if (i_s_tvalid && !(i_rst_n && o_s_tready)) begin
            // held request stays as it is
        end else if (point_q.size() > 0
                     && $urandom_range(99) >= send_idle_pct && i_rst_n) begin
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= point_q[0];
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // monitor: receiver stalls and field checks
    always @(posedge i_clk) begin
        t_pixel exp_px, got;
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.u = o_m_tdata[9:0];
            got.v = o_m_tdata[19:10];
            got.depth = o_m_tdata[42:20];
            got.hit = o_m_tuser[0];
            n_pixels++;
            if (pixel_q.size() == 0) begin
                $error("pixel result with nothing expected");
                errors++;
            end else begin
                exp_px = pixel_q.pop_front();
                if (got.hit) n_hits++;
                if (got.u !== exp_px.u) begin
                    $error("pixel_u exp %0d got %0d", exp_px.u, got.u); errors++;
                end
                if (got.v !== exp_px.v) begin
                    $error("pixel_v exp %0d got %0d", exp_px.v, got.v); errors++;
                end
                if (got.depth !== exp_px.depth) begin
                    $error("depth exp %0d got %0d", exp_px.depth, got.depth); errors++;
                end
                if (got.hit !== exp_px.hit) begin
                    $error("hit exp %0d got %0d", exp_px.hit, got.hit); errors++;
                end
            end
        end
        hold_now = hold_cycles > 0;
        if (hold_now) hold_cycles--;
        i_m_tready <= !hold_now && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic cfg_write(logic [XW-1:0] idx, logic [VW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            lppp_pkg::CFG_FOCAL:  cam.focal_length = val;
            lppp_pkg::CFG_CU:     cam.center_u = val;
            lppp_pkg::CFG_CV:     cam.center_v = val;
            lppp_pkg::CFG_DMIN:   cam.depth_min = val[DW-1:0];
            lppp_pkg::CFG_DMAX:   cam.depth_max = val[DW-1:0];
            lppp_pkg::CFG_WIDTH:  cam.image_width = val[SW-1:0];
            lppp_pkg::CFG_HEIGHT: cam.image_height = val[SW-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_camera(int f, int cu, int cv, int dmin, int dmax, int w, int h);
        cfg_write(lppp_pkg::CFG_FOCAL, VW'(f));
        cfg_write(lppp_pkg::CFG_CU, VW'(cu));
        cfg_write(lppp_pkg::CFG_CV, VW'(cv));
        cfg_write(lppp_pkg::CFG_DMIN, VW'(dmin));
        cfg_write(lppp_pkg::CFG_DMAX, VW'(dmax));
        cfg_write(lppp_pkg::CFG_WIDTH, VW'(w));
        cfg_write(lppp_pkg::CFG_HEIGHT, VW'(h));
    endtask

    // wait for the block to drain, including its pipeline
    task automatic drain();
        while (point_q.size() != 0 || i_s_tvalid || pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_coord();
        logic [23:0] c;
        case ($urandom_range(3))
            0: c = 24'($urandom);                              // anything
            1: c = 24'($urandom_range(800000));                 // near positive
            2: c = 24'(-int'($urandom_range(200000)));         // near negative
            default: c = 24'(int'($urandom_range(60000)) - 30000);
        endcase
        return c;
    endfunction

    // points mostly in front of the camera so that projection gets exercised
    task automatic queue_random(int count);
        t_point p;
        repeat (count) begin
            p.x = ($urandom_range(99) < 75) ? 24'(2418 + $urandom_range(700000))
                                             : rand_coord();
            p.y = rand_coord();
            p.z = rand_coord();
            point_q.push_back(p);
        end
    endtask

    task automatic queue_point(int x, int y, int z);
        t_point p;
        p.x = 24'(x);
        p.y = 24'(y);
        p.z = 24'(z);
        point_q.push_back(p);
    endtask

    initial begin
        cam = '{39970304, 20709510, 16390011, 6554, 655360, 640, 480};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: field extremes, on-axis, depth window edges, behind camera
        queue_point(0, 0, 0);
        queue_point(8388607, 8388607, 8388607);
        queue_point(-8388608, -8388608, -8388608);
        queue_point(8388607, -8388608, 0);
        queue_point(-8388608, 8388607, -1);
        queue_point(65536, 0, -4194);
        queue_point(2418, 0, 0);                 // Z = 0
        queue_point(2418 + 6554, 0, 0);          // Z at depth_min
        queue_point(2418 + 6553, 0, 0);          // just below
        queue_point(2418 + 655360, 0, 0);        // Z at depth_max
        queue_point(2418 + 655361, 0, 0);        // just above
        queue_point(131072, 65536, 65536);
        queue_point(131072, -65536, -65536);
        queue_point(32768, -800000, 0);          // far off the right edge
        queue_point(2417, 1, 1);                 // Z negative
        drain();

        // empty window, depth_min of zero, oversized and zero images
        load_camera(134217727, 134217727, 134217727, 0, 8388607, 2047, 2047);
        queue_point(2418, 0, 0);
        queue_point(2419, 0, 0);
        queue_point(8388607, 0, 0);
        queue_random(20);
        drain();
        load_camera(0, 0, 0, 100000, 50000, 0, 1);
        queue_point(2418 + 70000, 0, 0);
        queue_random(10);
        drain();
        load_camera(65536 * 300, 65536 * 512, 65536 * 512, 1, 8388607, 1024, 1024);
        queue_point(2419, 1, 1);
        queue_random(10);
        drain();

        // random phases under changing stall mixes
        send_idle_pct = 15; recv_idle_pct = 45;
        load_camera(39970304, 20709510, 16390011, 6554, 655360, 640, 480);
        queue_random(300);
        drain();
        send_idle_pct = 45; recv_idle_pct = 15;
        load_camera($urandom_range(134217727) >> $urandom_range(8), $urandom_range(134217727),
                    $urandom_range(134217727) >> 2, $urandom_range(30000),
                    $urandom_range(8388607), $urandom_range(1, 1024), $urandom_range(1, 1024));
        queue_random(300);
        drain();

        // long receiver hold-off: pipeline fills and input stalls
        send_idle_pct = 0; recv_idle_pct = 0;
        load_camera(65536 * 400, 65536 * 320, 65536 * 240, 1000, 2000000, 640, 480);
        hold_cycles = 200;
        queue_random(300);
        drain();

        $display("checked %0d pixel results from %0d points, %0d hits",
                 n_pixels, n_points, n_hits);
        $display("covered default, extreme, empty-window and random camera settings");
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
